// File: design/fpm_pkg.sv
`default_nettype none
package fpm_pkg;
  localparam int PagesPerBlock = 16;
  localparam int PhysBlocks = 16;
  localparam int LogicalPages = 128;
  localparam int PhysPages = 256;
  localparam int BlkW = 4;
  localparam int PgW = 4;
  localparam int LpW = 7;
  localparam int PpW = 8;
  localparam int CntW = 6;
  localparam logic [CntW-1:0] FreeMark = 6'd63;
  localparam logic [4:0] NoVictim = 5'd17;

  localparam logic [1:0] OpRead = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [2:0] CmdReadMapped = 3'd0;
  localparam logic [2:0] CmdReadUnmapped = 3'd1;
  localparam logic [2:0] CmdMoveRead = 3'd2;
  localparam logic [2:0] CmdProgram = 3'd3;
  localparam logic [2:0] CmdErase = 3'd4;
  localparam logic [2:0] CmdCleared = 3'd5;
endpackage
`default_nettype wire

// File: design/fpm_ram.sv
`default_nettype none
module fpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/flash_page_map_with_greedy_gc.sv
`default_nettype none
// Channel | Dir | Handshake                 | Fields
// in      | in  | in_valid_i / in_stall_o   | op_i, logical_page_i
// out     | out | out_valid_o / out_stall_i | command_o, block_o, page_o, owner_page_o, status_o, last_o
// One item is handled at a time; the input stalls from acceptance until the item's last word
// is loaded and any map update, erase and rescan after it are done. A read's word follows the
// forward-map read. A write's program word follows that read, any collection and the search
// for a new block; an emptied old block adds an erase and a victim rescan. Collection checks
// each victim page, moves each valid one, then erases and rescans. After reset, and after a
// clear, a sweep clears the maps. A stalled output word holds the next word.
module flash_page_map_with_greedy_gc (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [6:0] logical_page_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      command_o,
  output logic [3:0]      block_o,
  output logic [3:0]      page_o,
  output logic [6:0]      owner_page_o,
  output logic            status_o,
  output logic            last_o
);
  localparam int SW = 5;
  localparam logic [SW-1:0] SClr = 5'd0, SIdle = 5'd1, SRdWait = 5'd2,
    SRdOut = 5'd3, SWrRd = 5'd4, SWrChk = 5'd5, SGcRd = 5'd6, SGcChk = 5'd7,
    STakeScan = 5'd8, STakeDone = 5'd9, SGcFin = 5'd10, SEmit = 5'd11,
    SWrTake = 5'd12, SWrOld = 5'd13, SScan = 5'd14, SScanEnd = 5'd15,
    SGcErase = 5'd16, SWrPost = 5'd17, SOldErase = 5'd18, SDone = 5'd19;

  logic [SW-1:0] state_q, state_d, ret_q, ret_d;
  logic [SW-1:0] after_emit_q, after_emit_d;

  // Memories: forward map (valid + physical page), reverse map (valid + owner).
  logic fwd_we, rev_we;
  logic [6:0] fwd_wa, fwd_ra;
  logic [8:0] fwd_wd, fwd_rd;
  logic [7:0] rev_wa, rev_ra, rev_wd, rev_rd;

  fpm_ram #(.Width(9), .Depth(fpm_pkg::LogicalPages)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_wa), .wdata_i(fwd_wd),
    .raddr_i(fwd_ra), .rdata_o(fwd_rd));
  fpm_ram #(.Width(8), .Depth(fpm_pkg::PhysPages)) u_rev (
    .clk_i, .we_i(rev_we), .waddr_i(rev_wa), .wdata_i(rev_wd),
    .raddr_i(rev_ra), .rdata_o(rev_rd));

  // Small per-block counters and scalar state.
  logic [5:0] bvp_q [16];
  logic [5:0] bvp_d [16];
  logic [4:0] free_q, free_d, vcnt_q, vcnt_d;
  logic [3:0] ob_q, ob_d, opg_q, opg_d, vb_q, vb_d;
  logic       started_q, started_d;

  // Work registers.
  logic [6:0] lp_q, lp_d, own_q, own_d;
  logic [8:0] old_q, old_d;
  logic [7:0] sweep_q, sweep_d;
  logic [4:0] idx_q, idx_d;
  logic [3:0] nb_q, nb_d, np_q, np_d, eb_q, eb_d;
  logic       fail_q, fail_d;

  // Staging for the next word.
  logic       ov_q, ov_d;
  logic [2:0] cmd_q, cmd_d;
  logic [3:0] blk_q, blk_d, pg_q, pg_d;
  logic [6:0] ow_q, ow_d;
  logic       st_q, st_d, ls_q, ls_d;

  // Output word register, loaded only when the previous word is gone.
  logic       emit_go;
  logic [2:0] wcmd_q;
  logic [3:0] wblk_q, wpg_q;
  logic [6:0] wow_q;
  logic       wst_q, wls_q;

  assign emit_go      = (state_q == SEmit) && (!ov_q || !out_stall_i);
  assign out_valid_o  = ov_q;
  assign command_o    = wcmd_q;
  assign block_o      = wblk_q;
  assign page_o       = wpg_q;
  assign owner_page_o = wow_q;
  assign status_o     = wst_q;
  assign last_o       = wls_q;
  assign in_stall_o   = (state_q != SIdle);

  logic [3:0] scan_j, old_b;
  logic [5:0] bvp_ob;
  assign scan_j = ob_q + idx_q[3:0];
  assign old_b  = old_q[7:4];
  assign bvp_ob = bvp_q[old_b];

  always_comb begin
    state_d = state_q; ret_d = ret_q; after_emit_d = after_emit_q;
    bvp_d = bvp_q; free_d = free_q; vcnt_d = vcnt_q; ob_d = ob_q;
    opg_d = opg_q; vb_d = vb_q; started_d = started_q;
    lp_d = lp_q; own_d = own_q; old_d = old_q; sweep_d = sweep_q;
    idx_d = idx_q; nb_d = nb_q; np_d = np_q; eb_d = eb_q; fail_d = fail_q;
    ov_d = ov_q; cmd_d = cmd_q; blk_d = blk_q; pg_d = pg_q; ow_d = ow_q;
    st_d = st_q; ls_d = ls_q;
    fwd_we = 1'b0; fwd_wa = lp_q; fwd_wd = '0; fwd_ra = lp_q;
    rev_we = 1'b0; rev_wa = '0; rev_wd = '0; rev_ra = {vb_q, idx_q[3:0]};
    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (state_q)
      SClr: begin
        fwd_we = 1'b1; fwd_wa = sweep_q[6:0];
        rev_we = 1'b1; rev_wa = sweep_q;
        sweep_d = sweep_q + 8'd1;
        if (sweep_q == 8'd255) state_d = SIdle;
      end
      SIdle: begin
        fwd_ra = logical_page_i;
        if (in_valid_i) begin
          lp_d = logical_page_i;
          if (op_i == fpm_pkg::OpRead) state_d = SRdWait;
          else if (op_i == fpm_pkg::OpWrite) state_d = SWrRd;
          else if (op_i == fpm_pkg::OpClear) begin
            for (int i = 0; i < 16; i++) bvp_d[i] = fpm_pkg::FreeMark;
            free_d = 5'd16; ob_d = '0; opg_d = '0; started_d = 1'b0;
            vb_d = '0; vcnt_d = fpm_pkg::NoVictim; sweep_d = '0;
            cmd_d = fpm_pkg::CmdCleared; blk_d = '0; pg_d = '0; ow_d = '0;
            st_d = 1'b0; ls_d = 1'b1;
            state_d = SEmit; after_emit_d = SClr;
          end
        end
      end
      SRdWait: state_d = SRdOut;
      SRdOut: begin
        ow_d = lp_q; st_d = 1'b0; ls_d = 1'b1;
        if (fwd_rd[8]) begin
          cmd_d = fpm_pkg::CmdReadMapped; blk_d = fwd_rd[7:4]; pg_d = fwd_rd[3:0];
        end else begin
          cmd_d = fpm_pkg::CmdReadUnmapped; blk_d = '0; pg_d = '0;
        end
        state_d = SEmit; after_emit_d = SIdle;
      end
      SWrRd: begin
        state_d = SWrChk; // read data valid next cycle
      end
      SWrChk: begin
        old_d = fwd_rd;
        idx_d = '0;
        if (free_q == 5'd0 && fwd_rd[8] && started_q &&
            vcnt_q == 5'(5'd15 - {1'b0, opg_q}) &&
            bvp_q[fwd_rd[7:4]] != {1'b0, vcnt_q} &&
            vb_q != ob_q && bvp_q[vb_q] == {1'b0, vcnt_q}) begin
          state_d = SGcRd;
        end else begin
          state_d = SWrTake;
        end
      end
      // Collection: walk the victim's pages.
      SGcRd: begin
        rev_ra = {vb_q, idx_q[3:0]};
        state_d = SGcChk;
      end
      SGcChk: begin
        if (rev_rd[7]) begin
          own_d = rev_rd[6:0];
          cmd_d = fpm_pkg::CmdMoveRead; blk_d = vb_q; pg_d = idx_q[3:0];
          ow_d = rev_rd[6:0]; st_d = 1'b0; ls_d = 1'b0;
          state_d = SEmit; after_emit_d = STakeScan; ret_d = SGcFin;
          idx_d = idx_q; fail_d = 1'b0;
        end else if (idx_q == 5'd15) begin
          state_d = SGcErase;
        end else begin
          idx_d = idx_q + 5'd1; state_d = SGcRd;
        end
      end
      SGcFin: begin
        if (fail_q) begin
          state_d = SWrOld; // abandon collection, continue with write
        end else begin
          fwd_we = 1'b1; fwd_wa = own_q; fwd_wd = {1'b1, nb_q, np_q};
          rev_we = 1'b1; rev_wa = {nb_q, np_q}; rev_wd = {1'b1, own_q};
          bvp_d[nb_q] = bvp_q[nb_q] + 6'd1;
          cmd_d = fpm_pkg::CmdProgram; blk_d = nb_q; pg_d = np_q; ow_d = own_q;
          st_d = 1'b0; ls_d = 1'b0;
          state_d = SEmit; after_emit_d = SGcRd;
          ret_d = SGcFin;
          // clear the moved victim slot after the program word
        end
      end
      SGcErase: begin
        eb_d = vb_q; idx_d = '0; ret_d = SWrOld;
        state_d = SOldErase;
      end
      // Page allocation (take_page): shared by collection and host write.
      STakeScan: begin
        if (after_emit_q == STakeScan && ret_q == SGcFin && fail_q == 1'b0 &&
            !started_q) begin
          started_d = 1'b1; ob_d = '0; opg_d = '0;
          if (free_q != 5'd0) free_d = free_q - 5'd1;
          bvp_d[0] = '0; nb_d = '0; np_d = '0; state_d = STakeDone;
        end else if (!started_q) begin
          started_d = 1'b1; ob_d = '0; opg_d = '0;
          if (free_q != 5'd0) free_d = free_q - 5'd1;
          bvp_d[0] = '0; nb_d = '0; np_d = '0; state_d = STakeDone;
        end else if (opg_q < 4'd15) begin
          opg_d = opg_q + 4'd1; nb_d = ob_q; np_d = opg_q + 4'd1;
          state_d = STakeDone;
        end else if (idx_q[4]) begin
          fail_d = 1'b1; state_d = STakeDone;
        end else if (bvp_q[scan_j] == fpm_pkg::FreeMark) begin
          ob_d = scan_j; opg_d = '0;
          if (free_q != 5'd0) free_d = free_q - 5'd1;
          bvp_d[scan_j] = '0; nb_d = scan_j; np_d = '0; state_d = STakeDone;
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end
      STakeDone: begin
        idx_d = {1'b0, eb_q};
        state_d = ret_q;
      end
      SWrTake: begin
        if (started_q && opg_q == 4'd15 && bvp_q[ob_q] < {1'b0, vcnt_q}) begin
          vcnt_d = bvp_q[ob_q][4:0]; vb_d = ob_q;
        end
        idx_d = '0; fail_d = 1'b0; ret_d = SWrPost; state_d = STakeScan;
        eb_d = '0;
      end
      SWrOld: begin
        // re-read the forward map after collection
        fwd_ra = lp_q; state_d = SWrTake; ret_d = SWrPost;
        after_emit_d = SWrRd;
      end
      SWrPost: begin
        if (fail_q) begin
          cmd_d = fpm_pkg::CmdProgram; blk_d = '0; pg_d = '0; ow_d = lp_q;
          st_d = 1'b1; ls_d = 1'b1; state_d = SEmit; after_emit_d = SIdle;
        end else begin
          fwd_we = 1'b1; fwd_wa = lp_q; fwd_wd = {1'b1, nb_q, np_q};
          rev_we = 1'b1; rev_wa = {nb_q, np_q}; rev_wd = {1'b1, lp_q};
          bvp_d[nb_q] = bvp_q[nb_q] + 6'd1;
          cmd_d = fpm_pkg::CmdProgram; blk_d = nb_q; pg_d = np_q; ow_d = lp_q;
          st_d = 1'b0;
          ls_d = !old_q[8] || bvp_ob == fpm_pkg::FreeMark ||
                 (bvp_ob == 6'd0 && old_b != nb_q) ||
                 (old_b == nb_q && bvp_ob != 6'd0) ||
                 (old_b != nb_q && bvp_ob != 6'd1);
          state_d = SEmit; after_emit_d = old_q[8] ? SDone : SIdle;
        end
      end
      SDone: begin
        // invalidate the old copy
        rev_we = 1'b1; rev_wa = old_q[7:0]; rev_wd = '0;
        if (bvp_ob == fpm_pkg::FreeMark || bvp_ob == 6'd0) begin
          state_d = SIdle;
        end else begin
          bvp_d[old_b] = bvp_ob - 6'd1;
          if (old_b != ob_q && (bvp_ob - 6'd1) < {1'b0, vcnt_q}) begin
            vcnt_d = 5'(bvp_ob - 6'd1); vb_d = old_b;
          end
          if (bvp_ob == 6'd1) begin
            eb_d = old_b; idx_d = '0; ret_d = SIdle; state_d = SOldErase;
          end else state_d = SIdle;
        end
      end
      // Erase: clear 16 reverse entries, free the block, emit, rescan.
      SOldErase: begin
        rev_we = 1'b1; rev_wa = {eb_q, idx_q[3:0]}; rev_wd = '0;
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd15) begin
          bvp_d[eb_q] = fpm_pkg::FreeMark; free_d = free_q + 5'd1;
          cmd_d = fpm_pkg::CmdErase; blk_d = eb_q; pg_d = '0; ow_d = '0;
          st_d = 1'b0; ls_d = (ret_q == SIdle);
          vcnt_d = fpm_pkg::NoVictim; idx_d = '0;
          state_d = SEmit; after_emit_d = SScan;
        end
      end
      SScan: begin
        if (!(started_q && idx_q[3:0] == ob_q) &&
            bvp_q[idx_q[3:0]] < {1'b0, vcnt_q}) begin
          vcnt_d = bvp_q[idx_q[3:0]][4:0]; vb_d = idx_q[3:0];
        end
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd15) state_d = SScanEnd;
      end
      SScanEnd: state_d = ret_q;
      SEmit: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1; state_d = after_emit_q;
          if (after_emit_q == STakeScan) begin
            idx_d = '0; eb_d = idx_q[3:0];
          end
          if (after_emit_q == SGcRd) begin
            // clear moved victim slot and step to next page
            rev_we = 1'b1; rev_wa = {vb_q, eb_q}; rev_wd = '0;
            if (eb_q == 4'd15) state_d = SGcErase;
            else idx_d = {1'b0, eb_q + 4'd1};
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; ret_q <= SIdle; after_emit_q <= SIdle;
      for (int i = 0; i < 16; i++) bvp_q[i] <= fpm_pkg::FreeMark;
      free_q <= 5'd16; vcnt_q <= fpm_pkg::NoVictim; ob_q <= '0; opg_q <= '0;
      vb_q <= '0; started_q <= 1'b0; sweep_q <= '0; ov_q <= 1'b0;
      idx_q <= '0; fail_q <= 1'b0; eb_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; after_emit_q <= after_emit_d;
      bvp_q <= bvp_d; free_q <= free_d; vcnt_q <= vcnt_d; ob_q <= ob_d;
      opg_q <= opg_d; vb_q <= vb_d; started_q <= started_d;
      sweep_q <= sweep_d; ov_q <= ov_d; idx_q <= idx_d; fail_q <= fail_d;
      eb_q <= eb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lp_q <= lp_d; own_q <= own_d; old_q <= old_d;
    nb_q <= nb_d; np_q <= np_d;
    cmd_q <= cmd_d; blk_q <= blk_d; pg_q <= pg_d; ow_q <= ow_d;
    st_q <= st_d; ls_q <= ls_d;
  end

  // The output word changes only when it is free or being accepted.
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      wcmd_q <= cmd_q; wblk_q <= blk_q; wpg_q <= pg_q; wow_q <= ow_q;
      wst_q <= st_q; wls_q <= ls_q;
    end
  end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int unsigned CycleLimit = 2000000;
  localparam logic [11:0] FwdValid = 12'h800;
  localparam logic [11:0] RevValid = 12'h800;
  localparam logic [1:0] OpUnknown = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] op_i;
  logic [6:0] logical_page_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] command_o;
  logic [3:0] block_o;
  logic [3:0] page_o;
  logic [6:0] owner_page_o;
  logic       status_o;
  logic       last_o;

  flash_page_map_with_greedy_gc dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .op_i(op_i), .logical_page_i(logical_page_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .command_o(command_o), .block_o(block_o), .page_o(page_o),
    .owner_page_o(owner_page_o), .status_o(status_o), .last_o(last_o)
  );

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] block;
    logic [3:0] page;
    logic [6:0] owner;
    logic       status;
    logic       last;
  } flash_cmd_t;

  // Shadow copy of the translation state.
  logic [11:0] l2p [fpm_pkg::LogicalPages];
  logic [11:0] p2l [fpm_pkg::PhysPages];
  int unsigned blk_valid [fpm_pkg::PhysBlocks];
  int unsigned free_cnt, cur_blk, cur_pg, victim_blk, victim_cnt;
  bit          cur_open;

  flash_cmd_t expected_cmds [$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          random_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void map_reset();
    for (int i = 0; i < fpm_pkg::LogicalPages; i++) l2p[i] = '0;
    for (int i = 0; i < fpm_pkg::PhysPages; i++) p2l[i] = '0;
    for (int i = 0; i < fpm_pkg::PhysBlocks; i++) blk_valid[i] = fpm_pkg::FreeMark;
    free_cnt = fpm_pkg::PhysBlocks;
    cur_blk = 0;
    cur_pg = 0;
    cur_open = 0;
    victim_blk = 0;
    victim_cnt = fpm_pkg::NoVictim;
  endfunction

  function automatic void push_cmd(logic [2:0] c, int unsigned b, int unsigned p,
                                   int unsigned own, bit st);
    flash_cmd_t w;
    w.command = c;
    w.block = b[3:0];
    w.page = p[3:0];
    w.owner = own[6:0];
    w.status = st;
    w.last = 1'b0;
    expected_cmds.push_back(w);
  endfunction

  function automatic bit alloc_page(output int unsigned b, output int unsigned p);
    int unsigned i, j;
    b = 0;
    p = 0;
    if (!cur_open) begin
      cur_open = 1;
      cur_blk = 0;
      cur_pg = 0;
      if (free_cnt > 0) free_cnt--;
      blk_valid[0] = 0;
    end else if (cur_pg >= fpm_pkg::PagesPerBlock - 1) begin
      j = 0;
      for (i = 0; i < fpm_pkg::PhysBlocks; i++) begin
        j = (cur_blk + i) % fpm_pkg::PhysBlocks;
        if (blk_valid[j] == fpm_pkg::FreeMark) break;
      end
      if (i == fpm_pkg::PhysBlocks) return 0;
      cur_blk = j;
      cur_pg = 0;
      if (free_cnt > 0) free_cnt--;
      blk_valid[j] = 0;
    end else begin
      cur_pg++;
    end
    b = cur_blk;
    p = cur_pg;
    return 1;
  endfunction

  function automatic void pick_victim();
    victim_cnt = fpm_pkg::NoVictim;
    for (int unsigned i = 0; i < fpm_pkg::PhysBlocks; i++) begin
      if (cur_open && i == cur_blk) continue;
      if (blk_valid[i] < victim_cnt) begin
        victim_cnt = blk_valid[i];
        victim_blk = i;
      end
    end
  endfunction

  function automatic void erase_blk(int unsigned b);
    for (int i = 0; i < fpm_pkg::PagesPerBlock; i++)
      p2l[b * fpm_pkg::PagesPerBlock + i] = '0;
    blk_valid[b] = fpm_pkg::FreeMark;
    free_cnt++;
    push_cmd(fpm_pkg::CmdErase, b, 0, 0, 0);
  endfunction

  function automatic void collect_victim();
    int unsigned v, own, nb, np;
    v = victim_blk;
    for (int unsigned i = 0; i < fpm_pkg::PagesPerBlock; i++) begin
      if (!p2l[v * fpm_pkg::PagesPerBlock + i][11]) continue;
      own = p2l[v * fpm_pkg::PagesPerBlock + i][10:0];
      push_cmd(fpm_pkg::CmdMoveRead, v, i, own, 0);
      if (!alloc_page(nb, np)) return;
      push_cmd(fpm_pkg::CmdProgram, nb, np, own, 0);
      if (own < fpm_pkg::LogicalPages)
        l2p[own] = FwdValid | 12'(nb * fpm_pkg::PagesPerBlock + np);
      p2l[nb * fpm_pkg::PagesPerBlock + np] = RevValid | 12'(own);
      p2l[v * fpm_pkg::PagesPerBlock + i] = '0;
      blk_valid[nb]++;
    end
    erase_blk(v);
    pick_victim();
  endfunction

  function automatic void write_page(int unsigned lp);
    int unsigned ob, opg, nb, np;
    logic [11:0] prev;
    prev = l2p[lp];
    if (free_cnt == 0 && prev[11] && cur_open) begin
      ob = prev[10:0] / fpm_pkg::PagesPerBlock;
      if (victim_cnt == fpm_pkg::PagesPerBlock - 1 - cur_pg && blk_valid[ob] != victim_cnt &&
          victim_blk != cur_blk && blk_valid[victim_blk] == victim_cnt)
        collect_victim();
    end
    prev = l2p[lp];
    if (cur_open && cur_pg == fpm_pkg::PagesPerBlock - 1 &&
        blk_valid[cur_blk] < victim_cnt) begin
      victim_cnt = blk_valid[cur_blk];
      victim_blk = cur_blk;
    end
    if (!alloc_page(nb, np)) begin
      push_cmd(fpm_pkg::CmdProgram, 0, 0, lp, 1);
      return;
    end
    l2p[lp] = FwdValid | 12'(nb * fpm_pkg::PagesPerBlock + np);
    p2l[nb * fpm_pkg::PagesPerBlock + np] = RevValid | 12'(lp);
    blk_valid[nb]++;
    push_cmd(fpm_pkg::CmdProgram, nb, np, lp, 0);
    if (!prev[11]) return;
    ob = prev[10:0] / fpm_pkg::PagesPerBlock;
    opg = prev[10:0] % fpm_pkg::PagesPerBlock;
    if (ob >= fpm_pkg::PhysBlocks) return;
    p2l[ob * fpm_pkg::PagesPerBlock + opg] = '0;
    if (blk_valid[ob] == fpm_pkg::FreeMark || blk_valid[ob] == 0) return;
    blk_valid[ob]--;
    if (ob != cur_blk && blk_valid[ob] < victim_cnt) begin
      victim_cnt = blk_valid[ob];
      victim_blk = ob;
    end
    if (blk_valid[ob] == 0) begin
      erase_blk(ob);
      pick_victim();
    end
  endfunction

  // Queue the commands that one request produces.
  function automatic void predict_request(logic [1:0] op, logic [6:0] lp);
    int n0;
    n0 = expected_cmds.size();
    if (op == fpm_pkg::OpRead) begin
      if (l2p[lp][11])
        push_cmd(fpm_pkg::CmdReadMapped, l2p[lp][10:0] / fpm_pkg::PagesPerBlock,
                 l2p[lp][10:0] % fpm_pkg::PagesPerBlock, lp, 0);
      else
        push_cmd(fpm_pkg::CmdReadUnmapped, 0, 0, lp, 0);
    end else if (op == fpm_pkg::OpWrite) begin
      write_page(lp);
    end else if (op == fpm_pkg::OpClear) begin
      map_reset();
      push_cmd(fpm_pkg::CmdCleared, 0, 0, 0, 0);
    end
    if (expected_cmds.size() > n0) expected_cmds[expected_cmds.size() - 1].last = 1'b1;
  endfunction

  // Check every accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected word cmd=%0d", command_o));
      end else begin
        flash_cmd_t w;
        w = expected_cmds.pop_front();
        if (command_o !== w.command)
          report_mismatch($sformatf("command %0d, want %0d", command_o, w.command));
        if (block_o !== w.block)
          report_mismatch($sformatf("block %0d, want %0d", block_o, w.block));
        if (page_o !== w.page)
          report_mismatch($sformatf("page %0d, want %0d", page_o, w.page));
        if (owner_page_o !== w.owner)
          report_mismatch($sformatf("owner %0d, want %0d", owner_page_o, w.owner));
        if (status_o !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, w.status));
        if (last_o !== w.last)
          report_mismatch($sformatf("last %0d, want %0d", last_o, w.last));
      end
    end
  end

  // Receiver stalls at random, except during the quiet stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= random_idle && ($urandom_range(99) < 33);
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Present one request and hold it until accepted.
  task automatic send_request(logic [1:0] op, logic [6:0] lp);
    while (random_idle && ($urandom_range(99) < 33)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    logical_page_i <= lp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(op, lp);
  endtask

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  typedef struct {
    logic [1:0] op;
    logic [6:0] lp;
    bit         has_word;
    flash_cmd_t word;
  } stim_row_t;

  stim_row_t dir_rows [$];

  function automatic stim_row_t row(logic [1:0] op, logic [6:0] lp, bit hw = 0,
                                    flash_cmd_t w = '0);
    stim_row_t r;
    r.op = op;
    r.lp = lp;
    r.has_word = hw;
    r.word = w;
    return r;
  endfunction

  initial begin
    flash_cmd_t w;
    int unsigned fill_lp;
    error_count = 0;
    cycle_count = 0;
    random_idle = 1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = fpm_pkg::OpRead;
    logical_page_i = '0;
    map_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; fixed expectations where obvious.
    dir_rows.push_back(row(fpm_pkg::OpRead, 7'd0, 1,
                           {fpm_pkg::CmdReadUnmapped, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1}));
    dir_rows.push_back(row(fpm_pkg::OpRead, 7'd127, 1,
                           {fpm_pkg::CmdReadUnmapped, 4'd0, 4'd0, 7'd127, 1'b0, 1'b1}));
    dir_rows.push_back(row(fpm_pkg::OpWrite, 7'd0, 1,
                           {fpm_pkg::CmdProgram, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1}));
    dir_rows.push_back(row(fpm_pkg::OpRead, 7'd0, 1,
                           {fpm_pkg::CmdReadMapped, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1}));
    dir_rows.push_back(row(fpm_pkg::OpWrite, 7'd127));
    dir_rows.push_back(row(fpm_pkg::OpRead, 7'd127));
    dir_rows.push_back(row(OpUnknown, 7'd5));
    dir_rows.push_back(row(fpm_pkg::OpWrite, 7'd0));
    dir_rows.push_back(row(fpm_pkg::OpWrite, 7'd0));
    dir_rows.push_back(row(fpm_pkg::OpRead, 7'd0));
    dir_rows.push_back(row(fpm_pkg::OpWrite, 7'h55));
    dir_rows.push_back(row(fpm_pkg::OpWrite, 7'h2a));
    dir_rows.push_back(row(fpm_pkg::OpClear, 7'd127, 1,
                           {fpm_pkg::CmdCleared, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1}));
    dir_rows.push_back(row(fpm_pkg::OpRead, 7'd0, 1,
                           {fpm_pkg::CmdReadUnmapped, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1}));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_word) begin
        send_request(dir_rows[i].op, dir_rows[i].lp);
        w = expected_cmds[expected_cmds.size() - 1];
        if (w !== dir_rows[i].word) report_mismatch($sformatf("predictor row %0d", i));
      end else begin
        send_request(dir_rows[i].op, dir_rows[i].lp);
      end
    end
    drain_queue();

    // Fill the whole logical space, then rewrite hot pages to force collection.
    random_idle = 0;
    for (int i = 0; i < 128; i++) send_request(fpm_pkg::OpWrite, i[6:0]);
    random_idle = 1;
    for (int i = 0; i < 120; i++) begin
      fill_lp = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(15);
      send_request(($urandom_range(9) == 0) ? fpm_pkg::OpRead : fpm_pkg::OpWrite,
                   fill_lp[6:0]);
    end
    drain_queue();

    // Mixed random traffic with rare clears and unknown ops.
    for (int i = 0; i < 110; i++) begin
      logic [1:0] rop;
      int unsigned pick;
      pick = $urandom_range(99);
      rop = (pick < 55) ? fpm_pkg::OpWrite : (pick < 93) ? fpm_pkg::OpRead :
            (pick < 97) ? OpUnknown : fpm_pkg::OpClear;
      send_request(rop, 7'($urandom_range(127)));
    end
    in_valid_i <= 1'b0;

    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_cmds.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
